### design/cfpp_pkg.sv
// shared types, constants and crc function for the framed packet parser
package cfpp_pkg;

  localparam int unsigned LEN_LIMIT_MAX = 1024;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int LEN_W       = 11;
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 32;
  localparam int TDATA_W     = 168;
  localparam int TUSER_W     = 4;
  localparam int TDATA_PAD_W = TDATA_W - (8 + INDEX_W + 8 + 8 + 4 * COUNT_W);

  localparam logic [LEN_W-1:0] LIMIT_CAP =
    (LEN_LIMIT_MAX > 2047) ? {LEN_W{1'b1}} : LEN_W'(LEN_LIMIT_MAX);

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET     = 11'd1024;
  localparam logic [7:0]       SYNC_FIRST_RESET  = 8'd165;
  localparam logic [7:0]       SYNC_SECOND_RESET = 8'd90;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_LEN     = 2'd0,
    CFG_SYNC_FIRST  = 2'd1,
    CFG_SYNC_SECOND = 2'd2
  } cfg_addr_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_len;
    logic [7:0]       sync_first;
    logic [7:0]       sync_second;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] length_error_count;
    logic [COUNT_W-1:0] crc_error_count;
    logic [COUNT_W-1:0] lost_count;
    logic [COUNT_W-1:0] good_count;
    logic [7:0]         gap;
    logic [7:0]         sequence_res;
    logic [INDEX_W-1:0] payload_index;
    logic [7:0]         payload_byte;
    logic               length_error;
    logic               crc_error;
    logic               frame_good;
    logic               payload_valid;
  } result_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/crc_framed_packet_parser_top.sv
// top level of the sync word framed packet parser with crc-8 check
//
// one link byte enters per transfer on the s_ channel (s_tdata); every byte
// gives exactly one result transfer on the m_ channel. m_tuser carries the
// per-byte flags, m_tdata the payload byte with its index, the sequence and
// gap of a good frame and the four running totals after this byte.
// configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce: index 0 max payload length, 1 first sync byte, 2 second.
// a byte is held in the input register and parsed on its way into the
// result register, which offers its result on m_. one byte per cycle is
// sustained while the receiver takes every result; the limit is the single
// parse step between the two registers, which also updates the frame state.
// when the receiver stalls, the result register holds, then the input
// register fills and s_tready drops; nothing is lost or repeated.
// reset (rst, synchronous) empties both registers, restarts the sync hunt,
// clears the totals and loads the default configuration.
module crc_framed_packet_parser_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // rx_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // payload_byte, payload_index, sequence_res, gap, good_count, lost_count,
  // crc_error_count, length_error_count, zero fill
  output logic [cfpp_pkg::TDATA_W-1:0]     m_tdata,
  // payload_valid, frame_good, crc_error, length_error
  output logic [cfpp_pkg::TUSER_W-1:0]     m_tuser,
  input  logic                             cfg_we,
  input  logic [cfpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfpp_pkg::*;

  cfg_t       cfg;
  result_t    result;
  result_t    out_result;
  logic       in_full;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       step;

  assign step     = in_full && (!out_valid || m_tready);
  assign s_tready = !in_full || step;

  cfpp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfpp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (step) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{TDATA_PAD_W{1'b0}},
                     out_result.length_error_count,
                     out_result.crc_error_count,
                     out_result.lost_count,
                     out_result.good_count,
                     out_result.gap,
                     out_result.sequence_res,
                     out_result.payload_index,
                     out_result.payload_byte};
  assign m_tuser  = {out_result.length_error,
                     out_result.crc_error,
                     out_result.frame_good,
                     out_result.payload_valid};

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser))
    else $error("more than one result flag set");

  a_no_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[17:0] == 18'd0))
    else $error("payload fields set on a non-payload result");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_full && !step) |=> (in_full && $stable(in_byte)))
    else $error("input register lost a waiting byte");

  a_good_count_step: assert property (@(posedge clk) disable iff (rst)
    (step && result.frame_good) |-> (result.good_count != out_result.good_count))
    else $error("good frame did not advance the good count");
`endif

endmodule

### design/cfpp_cfg_regs.sv
// configuration registers written through the plain write port
module cfpp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cfpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cfpp_pkg::cfg_t                  cfg
);
  import cfpp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len     <= MAX_LEN_RESET;
      cfg.sync_first  <= SYNC_FIRST_RESET;
      cfg.sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr_t'(cfg_index))
        CFG_MAX_LEN:     cfg.max_len     <= cfg_data;
        CFG_SYNC_FIRST:  cfg.sync_first  <= cfg_data[7:0];
        CFG_SYNC_SECOND: cfg.sync_second <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### design/cfpp_parser.sv
// frame parser state machine, crc check and running counters
module cfpp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  cfpp_pkg::cfg_t    cfg,
  output cfpp_pkg::result_t result
);
  import cfpp_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC_A  = 3'd0,
    PH_SYNC_B  = 3'd1,
    PH_SEQ     = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_BODY    = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  phase_t             phase, phase_next;
  logic [7:0]         frame_sequence, frame_sequence_next;
  logic [7:0]         crc_acc, crc_acc_next;
  logic [7:0]         length_high, length_high_next;
  logic [LEN_W-1:0]   frame_length, frame_length_next;
  logic [LEN_W-1:0]   byte_position, byte_position_next;
  logic [7:0]         previous_sequence, previous_sequence_next;
  logic               have_previous, have_previous_next;
  logic [COUNT_W-1:0] good_total, good_total_next;
  logic [COUNT_W-1:0] lost_total, lost_total_next;
  logic [COUNT_W-1:0] crc_error_total, crc_error_total_next;
  logic [COUNT_W-1:0] length_error_total, length_error_total_next;

  logic [15:0]        len;
  logic [LEN_W-1:0]   limit;
  logic [7:0]         crc_byte;
  logic [LEN_W-1:0]   pos_inc;
  logic [7:0]         gap_calc;

  assign len      = {length_high, rx_byte};
  assign limit    = (cfg.max_len > LIMIT_CAP) ? LIMIT_CAP : cfg.max_len;
  assign crc_byte = crc8_step((phase == PH_SEQ) ? CRC_INIT : crc_acc, rx_byte);
  assign pos_inc  = byte_position + LEN_W'(1);
  assign gap_calc = frame_sequence - previous_sequence - 8'd1;

  always_comb begin
    phase_next              = phase;
    frame_sequence_next     = frame_sequence;
    crc_acc_next            = crc_acc;
    length_high_next        = length_high;
    frame_length_next       = frame_length;
    byte_position_next      = byte_position;
    previous_sequence_next  = previous_sequence;
    have_previous_next      = have_previous;
    good_total_next         = good_total;
    lost_total_next         = lost_total;
    crc_error_total_next    = crc_error_total;
    length_error_total_next = length_error_total;
    result                  = '0;

    unique case (phase)
      PH_SYNC_B: begin
        if (rx_byte == cfg.sync_second) begin
          phase_next = PH_SEQ;
        end else if (rx_byte != cfg.sync_first) begin
          phase_next = PH_SYNC_A;
        end
      end
      PH_SEQ: begin
        frame_sequence_next = rx_byte;
        crc_acc_next        = crc_byte;
        phase_next          = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_high_next = rx_byte;
        crc_acc_next     = crc_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len == 16'd0 || len > {5'd0, limit}) begin
          result.length_error     = 1'b1;
          length_error_total_next = length_error_total + COUNT_W'(1);
          phase_next              = PH_SYNC_A;
        end else begin
          frame_length_next  = len[LEN_W-1:0];
          crc_acc_next       = crc_byte;
          byte_position_next = '0;
          phase_next         = PH_BODY;
        end
      end
      PH_BODY: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = byte_position[INDEX_W-1:0];
        crc_acc_next         = crc_byte;
        byte_position_next   = pos_inc;
        if (pos_inc >= frame_length) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next = PH_SYNC_A;
        if (crc_acc != rx_byte) begin
          result.crc_error     = 1'b1;
          crc_error_total_next = crc_error_total + COUNT_W'(1);
        end else begin
          if (have_previous) begin
            result.gap      = gap_calc;
            lost_total_next = lost_total + COUNT_W'(gap_calc);
          end
          have_previous_next     = 1'b1;
          previous_sequence_next = frame_sequence;
          good_total_next        = good_total + COUNT_W'(1);
          result.frame_good      = 1'b1;
          result.sequence_res    = frame_sequence;
        end
      end
      default: begin
        // hunting, and the unused phase code
        phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC_B : PH_SYNC_A;
      end
    endcase

    result.good_count         = good_total_next;
    result.lost_count         = lost_total_next;
    result.crc_error_count    = crc_error_total_next;
    result.length_error_count = length_error_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SYNC_A;
      have_previous      <= 1'b0;
      good_total         <= '0;
      lost_total         <= '0;
      crc_error_total    <= '0;
      length_error_total <= '0;
    end else if (step) begin
      phase              <= phase_next;
      have_previous      <= have_previous_next;
      good_total         <= good_total_next;
      lost_total         <= lost_total_next;
      crc_error_total    <= crc_error_total_next;
      length_error_total <= length_error_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_sequence    <= frame_sequence_next;
      crc_acc           <= crc_acc_next;
      length_high       <= length_high_next;
      frame_length      <= frame_length_next;
      byte_position     <= byte_position_next;
      previous_sequence <= previous_sequence_next;
    end
  end

endmodule

### bench/tb_crc_framed_packet_parser_top.sv
// testbench for the framed packet parser: random framed byte streams checked against a predictor
`timescale 1ns / 100ps

module tb_crc_framed_packet_parser_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 250;
  localparam logic [cfpp_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_SEQ,
    TAKE_LEN_HI,
    TAKE_LEN_LO,
    TAKE_PAYLOAD,
    TAKE_CRC
  } parse_phase_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic        frame_good;
    logic        crc_error;
    logic        length_error;
    logic [7:0]  sequence_res;
    logic [7:0]  gap;
    logic [31:0] good_count;
    logic [31:0] lost_count;
    logic [31:0] crc_error_count;
    logic [31:0] length_error_count;
  } parse_result_t;

  class frame_verdicts;
    logic [10:0]   max_len;
    logic [7:0]    sync_a;
    logic [7:0]    sync_b;
    parse_phase_t  phase;
    logic [7:0]    seq_now;
    logic [7:0]    crc_acc;
    logic [7:0]    len_hi;
    logic [10:0]   frame_len;
    logic [10:0]   pos;
    logic [7:0]    prev_seq;
    bit            have_prev;
    logic [31:0]   good_total;
    logic [31:0]   lost_total;
    logic [31:0]   crc_err_total;
    logic [31:0]   len_err_total;
    parse_result_t pending_results[$];
    int            errors;

    function new();
      max_len       = cfpp_pkg::MAX_LEN_RESET;
      sync_a        = cfpp_pkg::SYNC_FIRST_RESET;
      sync_b        = cfpp_pkg::SYNC_SECOND_RESET;
      phase         = HUNT_FIRST;
      seq_now       = '0;
      crc_acc       = '0;
      len_hi        = '0;
      frame_len     = '0;
      pos           = '0;
      prev_seq      = '0;
      have_prev     = 1'b0;
      good_total    = '0;
      lost_total    = '0;
      crc_err_total = '0;
      len_err_total = '0;
      errors        = 0;
    endfunction

    static function logic [7:0] crc_next(logic [7:0] acc, logic [7:0] data);
      logic [7:0] c;
      logic       msb;
      c = acc ^ data;
      repeat (8) begin
        msb = c[7];
        c = c << 1;
        if (msb) begin
          c = c ^ cfpp_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function int limit();
      if (max_len > cfpp_pkg::LEN_LIMIT_MAX) begin
        return int'(cfpp_pkg::LEN_LIMIT_MAX);
      end
      return max_len;
    endfunction

    function void write_reg(logic [cfpp_pkg::CFG_INDEX_W-1:0] idx, logic [10:0] value);
      case (idx)
        cfpp_pkg::CFG_MAX_LEN: begin
          max_len = value;
        end
        cfpp_pkg::CFG_SYNC_FIRST: begin
          sync_a = value[7:0];
        end
        cfpp_pkg::CFG_SYNC_SECOND: begin
          sync_b = value[7:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_rx_byte(logic [7:0] b);
      parse_result_t r;
      logic [15:0]   len;
      logic [7:0]    missed;
      r = '0;
      case (phase)
        HUNT_SECOND: begin
          if (b == sync_b) begin
            phase = TAKE_SEQ;
          end else if (b != sync_a) begin
            phase = HUNT_FIRST;
          end
        end
        TAKE_SEQ: begin
          seq_now = b;
          crc_acc = crc_next(cfpp_pkg::CRC_INIT, b);
          phase = TAKE_LEN_HI;
        end
        TAKE_LEN_HI: begin
          len_hi = b;
          crc_acc = crc_next(crc_acc, b);
          phase = TAKE_LEN_LO;
        end
        TAKE_LEN_LO: begin
          len = {len_hi, b};
          if (len == 16'd0 || len > limit()) begin
            r.length_error = 1'b1;
            len_err_total = len_err_total + 32'd1;
            phase = HUNT_FIRST;
          end else begin
            frame_len = len[10:0];
            crc_acc = crc_next(crc_acc, b);
            pos = '0;
            phase = TAKE_PAYLOAD;
          end
        end
        TAKE_PAYLOAD: begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
          r.payload_index = pos[9:0];
          crc_acc = crc_next(crc_acc, b);
          pos = pos + 11'd1;
          if (pos >= frame_len) begin
            phase = TAKE_CRC;
          end
        end
        TAKE_CRC: begin
          phase = HUNT_FIRST;
          if (crc_acc != b) begin
            r.crc_error = 1'b1;
            crc_err_total = crc_err_total + 32'd1;
          end else begin
            missed = 8'd0;
            if (have_prev) begin
              missed = seq_now - prev_seq - 8'd1;
              lost_total = lost_total + {24'd0, missed};
            end
            have_prev = 1'b1;
            prev_seq = seq_now;
            good_total = good_total + 32'd1;
            r.frame_good   = 1'b1;
            r.sequence_res = seq_now;
            r.gap          = missed;
          end
        end
        default: begin
          phase = (b == sync_a) ? HUNT_SECOND : HUNT_FIRST;
        end
      endcase
      r.good_count         = good_total;
      r.lost_count         = lost_total;
      r.crc_error_count    = crc_err_total;
      r.length_error_count = len_err_total;
      pending_results.push_back(r);
    endfunction

    function void same(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [cfpp_pkg::TDATA_W-1:0] tdata,
                               logic [cfpp_pkg::TUSER_W-1:0] tuser);
      parse_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, tuser %h tdata %h",
                 $time, tuser, tdata);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      same("payload_valid", want.payload_valid, tuser[0]);
      same("frame_good", want.frame_good, tuser[1]);
      same("crc_error", want.crc_error, tuser[2]);
      same("length_error", want.length_error, tuser[3]);
      same("payload_byte", want.payload_byte, tdata[7:0]);
      same("payload_index", want.payload_index, tdata[17:8]);
      same("sequence_res", want.sequence_res, tdata[25:18]);
      same("gap", want.gap, tdata[33:26]);
      same("good_count", want.good_count, tdata[65:34]);
      same("lost_count", want.lost_count, tdata[97:66]);
      same("crc_error_count", want.crc_error_count, tdata[129:98]);
      same("length_error_count", want.length_error_count, tdata[161:130]);
      same("tdata fill", '0, tdata[cfpp_pkg::TDATA_W-1:162]);
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [cfpp_pkg::TDATA_W-1:0]     m_tdata;
  logic [cfpp_pkg::TUSER_W-1:0]     m_tuser;
  logic                             cfg_we;
  logic [cfpp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cfpp_pkg::CFG_DATA_W-1:0]  cfg_data;

  frame_verdicts board;
  bit            calm;
  bit            hold_request;
  int            bytes_sent;
  int            quiet_cycles;
  logic [7:0]    next_seq;

  crc_framed_packet_parser_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("crc_framed_packet_parser_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return board.sync_a;
    end
    if (r == 1) begin
      return board.sync_b;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] bad_length();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      return 16'd0;
    end
    if (r == 1) begin
      return 16'(board.limit() + 1);
    end
    return 16'($urandom_range(board.limit() + 1, 65535));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    board.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] seq, input logic [15:0] len,
                            input bit spoil_crc, input bit salt);
    logic [7:0] crc;
    logic [7:0] b;
    crc = frame_verdicts::crc_next(cfpp_pkg::CRC_INIT, seq);
    crc = frame_verdicts::crc_next(crc, len[15:8]);
    send_byte(board.sync_a);
    send_byte(board.sync_b);
    send_byte(seq);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len == 16'd0 || len > board.limit()) begin
      return;
    end
    crc = frame_verdicts::crc_next(crc, len[7:0]);
    for (int i = 0; i < len; i++) begin
      if (salt) begin
        b = (i % 2 == 1) ? board.sync_b : board.sync_a;
      end else begin
        b = pick_payload();
      end
      crc = frame_verdicts::crc_next(crc, b);
      send_byte(b);
    end
    if (spoil_crc) begin
      crc = crc ^ (8'd1 << $urandom_range(0, 7));
    end
    send_byte(crc);
  endtask

  task automatic random_traffic(input int n);
    int          stop_at;
    int          r;
    int          top;
    logic [15:0] len;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      top = (board.limit() < 12) ? board.limit() : 12;
      if ($urandom_range(0, 9) == 0) begin
        top = (board.limit() < 64) ? board.limit() : 64;
      end
      if (top == 0) begin
        len = 16'($urandom);
      end else begin
        len = 16'($urandom_range(1, top));
      end
      if ($urandom_range(0, 9) != 0) begin
        next_seq = next_seq + 8'd1;
      end else begin
        next_seq = 8'($urandom);
      end
      if (r < 70) begin
        send_frame(next_seq, len, 1'b0, 1'b0);
      end else if (r < 80) begin
        send_frame(next_seq, len, 1'b1, 1'b0);
      end else if (r < 88) begin
        send_frame(next_seq, bad_length(), 1'b0, 1'b0);
      end else if (r < 94) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        // truncated frame, whose missing bytes are taken from the next frame
        send_byte(board.sync_a);
        send_byte(board.sync_b);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [cfpp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [10:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, value);
  endtask

  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin : receiver
    int stall;
    bit hold_taken;
    stall = 0;
    hold_taken = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        board.check_result(m_tdata, m_tuser);
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        m_tready <= (stall == 0);
      end
    end
  end

  initial begin : stimulus
    board = new();
    calm = 1'b1;
    bytes_sent = 0;
    next_seq = 8'd0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'd0;
    cfg_we    <= 1'b0;
    cfg_index <= cfpp_pkg::CFG_MAX_LEN;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, repeated first sync byte, each verdict
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(board.sync_a);
    send_frame(8'hFF, 16'd1, 1'b0, 1'b0);
    send_frame(8'h00, 16'd0, 1'b0, 1'b0);
    send_frame(8'h01, 16'hFFFF, 1'b0, 1'b0);
    send_frame(8'h05, 16'd2, 1'b1, 1'b1);
    drain(4);

    calm = 1'b0;
    random_traffic(100);
    drain(4);

    // smallest nonzero limit, sync bytes at the extremes, junk in the upper data bits
    write_reg(cfpp_pkg::CFG_MAX_LEN, 11'd1);
    write_reg(cfpp_pkg::CFG_SYNC_FIRST, {3'b111, 8'h00});
    write_reg(cfpp_pkg::CFG_SYNC_SECOND, {3'b101, 8'hFF});
    write_reg(CFG_SPARE, 11'h7FF);
    random_traffic(80);
    drain(4);

    // zero limit rejects every length
    write_reg(cfpp_pkg::CFG_MAX_LEN, 11'd0);
    random_traffic(40);
    drain(4);

    // limit above the cap, equal sync bytes
    write_reg(cfpp_pkg::CFG_MAX_LEN, 11'h7FF);
    write_reg(cfpp_pkg::CFG_SYNC_FIRST, 11'h07E);
    write_reg(cfpp_pkg::CFG_SYNC_SECOND, 11'h07E);
    calm = 1'b1;
    next_seq = next_seq + 8'd1;
    send_frame(next_seq, 16'd1025, 1'b0, 1'b0);
    send_frame(next_seq, 16'd30, 1'b0, 1'b0);
    calm = 1'b0;
    random_traffic(70);
    drain(4);

    write_reg(cfpp_pkg::CFG_MAX_LEN, 11'd1024);
    write_reg(cfpp_pkg::CFG_SYNC_FIRST, 11'd165);
    write_reg(cfpp_pkg::CFG_SYNC_SECOND, 11'd90);
    random_traffic(60);
    hold_request = 1'b1;
    random_traffic(180);
    drain(8);

    if (board.errors == 0) begin
      $display("crc_framed_packet_parser_top test passed");
    end else begin
      $display("crc_framed_packet_parser_top test failed");
    end
    $finish;
  end

endmodule

### files.f
design/cfpp_pkg.sv
design/cfpp_cfg_regs.sv
design/cfpp_parser.sv
design/crc_framed_packet_parser_top.sv
bench/tb_crc_framed_packet_parser_top.sv
